/* src/mm64_pkg.sv */
package mm64_pkg;

	// widest datapath the block is built for
	localparam int unsigned MaxWidth = 64;

	// one bit of headroom above the widest residue
	typedef logic [MaxWidth:0] wide_t;

	// keep a partial value below the modulus, value known below twice the modulus
	function automatic wide_t cond_sub(input wide_t x, input wide_t m);
		wide_t diff;
		diff = x - m;
		return (x >= m) ? diff : x;
	endfunction

endpackage

/* src/mm64_reduce.sv */
module mm64_reduce #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [DATA_WIDTH-1:0] in_a,
	input  logic [DATA_WIDTH-1:0] in_b,
	input  logic [DATA_WIDTH-1:0] modulus,
	output logic                  out_valid,
	output logic [DATA_WIDTH-1:0] out_a,
	output logic [DATA_WIDTH-1:0] out_b
);
	import mm64_pkg::*;

	localparam int unsigned W = DATA_WIDTH;

	// one register stage per bit of operand a
	logic         v_s   [W];
	logic [W-1:0] rem_s [W];
	logic [W-1:0] a_s   [W];
	logic [W-1:0] b_s   [W];

	for (genvar k = 0; k < W; k++) begin : g_stage
		logic         v_prev;
		logic [W-1:0] rem_prev;
		logic [W-1:0] a_prev;
		logic [W-1:0] b_prev;
		logic [W:0]   trial;
		wide_t        sub;

		// previous stage or the input beat
		if (k == 0) begin : g_first
			assign v_prev   = in_valid;
			assign rem_prev = '0;
			assign a_prev   = in_a;
			assign b_prev   = in_b;
		end else begin : g_next
			assign v_prev   = v_s[k-1];
			assign rem_prev = rem_s[k-1];
			assign a_prev   = a_s[k-1];
			assign b_prev   = b_s[k-1];
		end

		// bring in the next bit of a, top bit first, and subtract once
		assign trial = {rem_prev, a_prev[W-1-k]};
		assign sub   = cond_sub(wide_t'(trial), wide_t'(modulus));

		// valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= v_prev;
			end
		end

		// payload
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= sub[W-1:0];
				a_s[k]   <= a_prev;
				b_s[k]   <= b_prev;
			end
		end
	end

	assign out_valid = v_s[W-1];
	assign out_a     = rem_s[W-1];
	assign out_b     = b_s[W-1];

endmodule

/* src/mm64_mult.sv */
module mm64_mult #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [DATA_WIDTH-1:0] in_a,
	input  logic [DATA_WIDTH-1:0] in_b,
	input  logic [DATA_WIDTH-1:0] modulus,
	output logic                  out_valid,
	output logic [DATA_WIDTH-1:0] out_acc
);
	import mm64_pkg::*;

	localparam int unsigned W      = DATA_WIDTH;
	localparam int unsigned Stages = 2 * DATA_WIDTH;

	// two register stages per bit of b: double, then add
	logic         v_s   [Stages];
	logic [W-1:0] acc_s [Stages];
	logic [W-1:0] a_s   [Stages];
	logic [W-1:0] b_s   [Stages];

	for (genvar j = 0; j < Stages; j++) begin : g_stage
		localparam int unsigned Bit = W - 1 - (j / 2);

		logic         v_prev;
		logic [W-1:0] acc_prev;
		logic [W-1:0] a_prev;
		logic [W-1:0] b_prev;
		logic [W:0]   sum;
		wide_t        sub;

		// previous stage or the operands from the reduce stage (operand a reduced, b as it came in)
		if (j == 0) begin : g_first
			assign v_prev   = in_valid;
			assign acc_prev = '0;
			assign a_prev   = in_a;
			assign b_prev   = in_b;
		end else begin : g_next
			assign v_prev   = v_s[j-1];
			assign acc_prev = acc_s[j-1];
			assign a_prev   = a_s[j-1];
			assign b_prev   = b_s[j-1];
		end

		// doubling step or conditional add of a
		if ((j % 2) == 0) begin : g_double
			assign sum = {acc_prev, 1'b0};
		end else begin : g_add
			assign sum = b_prev[Bit] ? ({1'b0, acc_prev} + {1'b0, a_prev})
			                         : {1'b0, acc_prev};
		end

		assign sub = cond_sub(wide_t'(sum), wide_t'(modulus));

		// valid bit
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_prev;
			end
		end

		// payload
		always_ff @(posedge clk) begin
			if (en) begin
				acc_s[j] <= sub[W-1:0];
				a_s[j]   <= a_prev;
				b_s[j]   <= b_prev;
			end
		end
	end

	assign out_valid = v_s[Stages-1];
	assign out_acc   = acc_s[Stages-1];

endmodule

/* src/mm64_skid.sv */
module mm64_skid #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [DATA_WIDTH-1:0] in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [DATA_WIDTH-1:0] out_data
);
	import mm64_pkg::*;

	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] out_data_q;
	logic                  skid_valid_q;
	logic [DATA_WIDTH-1:0] skid_data_q;
	logic                  out_free;

	// upstream only waits once the spare slot is taken
	assign in_ready = !skid_valid_q;
	assign out_free = out_ready || !out_valid_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	// data registers
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (in_valid && in_ready) begin
			skid_data_q <= in_data;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* src/modular_multiply_64_top.sv */
// channel      | direction | beat contents
// s_axis       | in        | tdata: operand_a [63:0], operand_b [127:64]
// m_axis       | out       | tdata: product_mod [63:0]
// cfg          | in        | cfg_wdata: modulus, written when cfg_we is high
//
// one beat enters per cycle while s_axis_tready is high; the registers in order:
// DATA_WIDTH shift-subtract stages reduce operand_a, 2*DATA_WIDTH stages double and add,
// then the output register. arst_n clears all valid bits and sets the modulus to one.
// a stalled m_axis freezes the pipeline only once the spare output slot is full,
// so one more result is taken into that slot while a result waits.
module modular_multiply_64_top #(
	parameter int unsigned DATA_WIDTH = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,   // operand_a [63:0], operand_b [127:64]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,   // product_mod [63:0]
	input  logic         cfg_we,
	input  logic [63:0]  cfg_wdata
);
	import mm64_pkg::*;

	localparam int unsigned W = DATA_WIDTH;

	logic [63:0]  modulus_q;
	logic [W-1:0] mod_w;
	logic         en;
	logic         red_valid;
	logic [W-1:0] red_a;
	logic [W-1:0] red_b;
	logic         mul_valid;
	logic [W-1:0] mul_acc;
	logic [W-1:0] product;
	logic [W-1:0] out_w;

	// modulus register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= 64'd1;
		end else if (cfg_we) begin
			modulus_q <= cfg_wdata;
		end
	end

	assign mod_w         = modulus_q[W-1:0];
	assign s_axis_tready = en;

	// reduce operand_a below the modulus
	mm64_reduce #(
		.DATA_WIDTH (W)
	) u_reduce (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.in_a      (s_axis_tdata[W-1:0]),
		.in_b      (s_axis_tdata[64 +: W]),
		.modulus   (mod_w),
		.out_valid (red_valid),
		.out_a     (red_a),
		.out_b     (red_b)
	);

	// interleaved double and add
	mm64_mult #(
		.DATA_WIDTH (W)
	) u_mult (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (red_valid),
		.in_a      (red_a),
		.in_b      (red_b),
		.modulus   (mod_w),
		.out_valid (mul_valid),
		.out_acc   (mul_acc)
	);

	// a zero modulus gives a zero product
	assign product = (mod_w == '0) ? '0 : mul_acc;

	// output register with a spare slot
	mm64_skid #(
		.DATA_WIDTH (W)
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mul_valid),
		.in_ready  (en),
		.in_data   (product),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_w)
	);

	assign m_axis_tdata = 64'(out_w);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

// keeps the expected products in arrival order and checks each result beat
class mod_product_board;
	logic [63:0] modulus;
	logic [63:0] product_q[$];
	int errors;
	int results_seen;

	function new();
		modulus = 64'd1;
		errors = 0;
		results_seen = 0;
	endfunction

	function void set_modulus(logic [63:0] value);
		modulus = value;
	endfunction

	// exact product, reduced by the current modulus; a zero modulus gives zero
	function logic [63:0] product_mod_of(logic [63:0] a, logic [63:0] b);
		logic [127:0] full;
		logic [127:0] rem;
		if (modulus == 64'd0) begin
			return 64'd0;
		end
		full = {64'd0, a} * {64'd0, b};
		rem = full % {64'd0, modulus};
		return rem[63:0];
	endfunction

	task report(string msg);
		$display("error at %0t ns: %s", $time, msg);
		errors++;
	endtask

	// input beat accepted: operand_a in the low half, operand_b in the high half
	task note_operands(logic [127:0] beat);
		product_q.push_back(product_mod_of(beat[63:0], beat[127:64]));
	endtask

	task check_product(logic [63:0] got);
		logic [63:0] want;
		if (product_q.size() == 0) begin
			report($sformatf("result %0d = %h with nothing expected", results_seen, got));
		end else begin
			want = product_q.pop_front();
			if (got !== want) begin
				report($sformatf("result %0d product_mod %h, expected %h",
					results_seen, got, want));
			end
		end
		results_seen++;
	endtask
endclass

module tb_top;

	localparam int CycleLimit = 400000;
	localparam int Latency = 3 * 64 + 1;
	localparam int HoldCycles = 600;
	localparam int Phases = 12;
	localparam int PhaseItems = 108;
	localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TopBit = 64'h8000_0000_0000_0000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;   // operand_a [63:0], operand_b [127:64]
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;   // product_mod [63:0]
	logic         cfg_we;
	logic [63:0]  cfg_wdata;

	mod_product_board board;
	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_req;
	int cycles;

	modular_multiply_64_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	// clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	// watchdog
	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// beat monitor on both streams
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				board.note_operands(s_axis_tdata);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_product(m_axis_tdata);
			end
		end
	end

	// result side back-pressure, with a long hold-off on request
	initial begin : sink
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// offer one operand pair, idling at random first, and wait for its beat
	task send_operands(input logic [63:0] a, input logic [63:0] b);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {b, a};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	// stop offering and wait until every expected product has come back
	task drain;
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (board.product_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task write_modulus(input logic [63:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		board.set_modulus(value);
	endtask

	// operands biased towards the edges around the modulus
	function logic [63:0] pick_operand(input logic [63:0] m);
		case ($urandom_range(9))
			0: return 64'd0;
			1: return AllOnes;
			2: return m - 64'd1;
			3: return m;
			4: return m + 64'd1;
			5: return 64'd1 << $urandom_range(63);
			6: return 64'($urandom_range(1000));
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function logic [63:0] modulus_for(input int phase);
		case (phase)
			0: return AllOnes;
			1: return 64'hFFFF_FFFF_FFFF_FFC5;
			2: return 64'($urandom_range(1000, 2));
			3: return 64'h7FFF_FFFF_FFFF_FFFF;
			4: return TopBit;
			5: return 64'h0000_0000_FFFF_FFFB;
			7: return 64'd3;
			8: return {$urandom(), $urandom()} | TopBit;
			9: return {32'd0, $urandom()};
			10: return 64'd1;
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	// extremes for one modulus: zero operands, all ones, top residue, a multiple of m
	task directed_set(input logic [63:0] m);
		send_operands(64'd0, AllOnes);
		send_operands(AllOnes, 64'd0);
		send_operands(AllOnes, AllOnes);
		send_operands(m - 64'd1, m - 64'd1);
		send_operands(m, 64'd1);
	endtask

	initial begin : stimulus
		logic [63:0] m;
		board = new();
		tx_idle_pct = 18;
		rx_idle_pct = 74;
		hold_req = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part, starting on the reset modulus of one
		directed_set(64'd1);
		drain();
		write_modulus(AllOnes);
		directed_set(AllOnes);
		drain();
		write_modulus(64'd0);
		directed_set(64'd0);
		drain();
		write_modulus(64'd2);
		directed_set(64'd2);
		drain();
		write_modulus(TopBit);
		directed_set(TopBit);

		// random part, one modulus per phase
		for (int p = 0; p < Phases; p++) begin
			if (p < 4) begin
				tx_idle_pct = 18;
				rx_idle_pct = 74;
			end else if (p < 8) begin
				tx_idle_pct = 74;
				rx_idle_pct = 18;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			drain();
			m = modulus_for(p);
			write_modulus(m);
			// long result stall while operands keep coming
			if (p == 8) begin
				hold_req = 1'b1;
			end
			for (int i = 0; i < PhaseItems; i++) begin
				// sender waits for the pipeline to empty mid-phase
				if (p == 9 && i == PhaseItems / 2) begin
					drain();
				end
				send_operands(pick_operand(m), pick_operand(m));
			end
		end

		// wind down
		drain();
		repeat (Latency + 16) @(posedge clk);
		if (board.product_q.size() != 0) begin
			board.report($sformatf("%0d products never arrived", board.product_q.size()));
		end
		if (board.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/mm64_pkg.sv
src/mm64_reduce.sv
src/mm64_mult.sv
src/mm64_skid.sv
src/modular_multiply_64_top.sv
tb/sv/tb_top.sv
